[rtl/rol_pkg.sv]
// Shared types and codes for the recency order list.
package rol_pkg;

    // Operation codes carried by an input word.
    typedef enum logic [2:0] {
        OP_APPEND       = 3'd0,
        OP_PREPEND      = 3'd1,
        OP_MOVE_END     = 3'd2,
        OP_MOVE_FRONT   = 3'd3,
        OP_REMOVE_FIRST = 3'd4,
        OP_REMOVE_LAST  = 3'd5,
        OP_REMOVE       = 3'd6,
        OP_CLEAR        = 3'd7
    } t_opcode;

    // Command broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CMD_HOLD       = 3'd0,
        CMD_PUT_END    = 3'd1,
        CMD_PUT_FRONT  = 3'd2,
        CMD_CLOSE      = 3'd3,
        CMD_CLOSE_ALL  = 3'd4,
        CMD_MOVE_END   = 3'd5,
        CMD_MOVE_FRONT = 3'd6
    } t_cmd;

    typedef struct packed {
        logic en;
        t_cmd cmd;
    } t_cell_ctl;

endpackage

[rtl/rol_in_if.sv]
// Input channel of the recency order list: operation and block number.
interface rol_in_if #(
    parameter int ID_BITS = 8
);
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic [ID_BITS-1:0] block_id;

    modport source (output valid, output opcode, output block_id, input ready);
    modport sink   (input valid, input opcode, input block_id, output ready);
endinterface

[rtl/rol_out_if.sv]
// Result channel of the recency order list.
interface rol_out_if #(
    parameter int ID_BITS = 8,
    parameter int CNT_W   = 5
);
    logic               valid;
    logic               ready;
    logic [ID_BITS-1:0] block_out;
    logic               found;
    logic               list_empty;
    logic [CNT_W-1:0]   entry_count;
    logic               overflow;

    modport source (output valid, output block_out, output found, output list_empty,
                    output entry_count, output overflow, input ready);
    modport sink   (input valid, input block_out, input found, input list_empty,
                    input entry_count, input overflow, output ready);
endinterface

[rtl/rol_cell.sv]
// One position of the list: holds a block number and shifts with its neighbours.
module rol_cell #(
    parameter int IDX     = 0,
    parameter int ID_BITS = 8,
    parameter int CNT_W   = 5
) (
    input  logic               i_clk,
    input  rol_pkg::t_cell_ctl i_ctl,
    input  logic [ID_BITS-1:0] i_id,
    input  logic [CNT_W-1:0]   i_count,
    input  logic [ID_BITS-1:0] i_left,
    input  logic [ID_BITS-1:0] i_right,
    input  logic               i_hit,
    output logic               o_hit,
    output logic [ID_BITS-1:0] o_val
);
    import rol_pkg::*;

    localparam logic [CNT_W-1:0] POS      = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(IDX + 1);
    localparam bit               IS_HEAD  = (IDX == 0);

    logic [ID_BITS-1:0] r_val;
    logic [ID_BITS-1:0] n_val;
    logic               w_match;
    logic               w_at_end;
    logic               w_last;

    // The hit chain marks this cell and every cell behind the first copy.
    assign w_match  = (POS < i_count) && (r_val == i_id);
    assign o_hit    = i_hit | w_match;
    assign o_val    = r_val;
    assign w_at_end = (i_count == POS);
    assign w_last   = (i_count == POS_NEXT);

    always_comb begin
        n_val = r_val;
        unique case (i_ctl.cmd)
            CMD_HOLD: begin
                n_val = r_val;
            end
            CMD_PUT_END: begin
                if (w_at_end) n_val = i_id;
            end
            CMD_PUT_FRONT: begin
                n_val = IS_HEAD ? i_id : i_left;
            end
            CMD_CLOSE: begin
                if (o_hit) n_val = i_right;
            end
            CMD_CLOSE_ALL: begin
                n_val = i_right;
            end
            CMD_MOVE_END: begin
                if (w_last) n_val = i_id;
                else if (o_hit) n_val = i_right;
            end
            CMD_MOVE_FRONT: begin
                if (!i_hit) n_val = IS_HEAD ? i_id : i_left;
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) r_val <= n_val;
    end

endmodule

[rtl/recency_order_list.sv]
// Top level of the recency order list: cell chain, count and result register.
// The list takes one operation word per clock and returns its result word in the
// next cycle from a result register; a new word is taken whenever that register
// is empty or being emptied in the same cycle, so back-to-back words run at one
// per clock. The whole update happens in the accepting cycle: the first-copy search
// ripples through the chain of ENTRIES cells, and the longest path is that chain
// of comparisons followed by the shift into each cell. The list is empty after
// reset and needs no clearing pass.
module recency_order_list #(
    parameter int ENTRIES = 16,
    parameter int ID_BITS = 8,
    parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rol_in_if.sink    i_in,
    rol_out_if.source o_out
);
    import rol_pkg::*;

    localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    logic [ID_BITS-1:0] r_block_out;
    logic               r_found;
    logic               r_overflow;
    logic [ID_BITS-1:0] n_block_out;
    logic               n_found;
    logic               n_overflow;

    logic               w_accept;
    logic               w_full;
    logic               w_any;
    t_opcode            w_op;
    t_cell_ctl          w_ctl;
    logic [ID_BITS-1:0] w_tail;

    logic [ID_BITS-1:0] w_val   [ENTRIES];
    logic [ID_BITS-1:0] w_left  [ENTRIES];
    logic [ID_BITS-1:0] w_right [ENTRIES];
    logic               w_hit   [ENTRIES+1];

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_op       = t_opcode'(i_in.opcode);
    assign w_full     = (r_count == FULL);
    assign w_any      = (r_count != '0);
    assign w_hit[0]   = 1'b0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left[g] = '0;
        end else begin : g_mid_l
            assign w_left[g] = w_val[g-1];
        end
        if (g == ENTRIES - 1) begin : g_tail
            assign w_right[g] = '0;
        end else begin : g_mid_r
            assign w_right[g] = w_val[g+1];
        end

        rol_cell #(
            .IDX     (g),
            .ID_BITS (ID_BITS),
            .CNT_W   (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_id    (i_in.block_id),
            .i_count (r_count),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .i_hit   (w_hit[g]),
            .o_hit   (w_hit[g+1]),
            .o_val   (w_val[g])
        );
    end

    // The last valid entry, picked out by the fill count.
    always_comb begin
        w_tail = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_count == CNT_W'(i + 1)) w_tail = w_tail | w_val[i];
        end
    end

    always_comb begin
        w_ctl.en    = w_accept;
        w_ctl.cmd   = CMD_HOLD;
        n_count     = r_count;
        n_block_out = '0;
        n_found     = 1'b0;
        n_overflow  = 1'b0;
        unique case (w_op) inside
            OP_APPEND, OP_PREPEND: begin
                if (w_full) begin
                    n_overflow = 1'b1;
                end else begin
                    w_ctl.cmd = (w_op == OP_APPEND) ? CMD_PUT_END : CMD_PUT_FRONT;
                    n_count   = r_count + ONE;
                end
            end
            OP_MOVE_END, OP_MOVE_FRONT: begin
                if (w_hit[ENTRIES]) begin
                    n_found   = 1'b1;
                    w_ctl.cmd = (w_op == OP_MOVE_END) ? CMD_MOVE_END : CMD_MOVE_FRONT;
                end else if (w_full) begin
                    n_overflow = 1'b1;
                end else begin
                    w_ctl.cmd = CMD_PUT_END;
                    n_count   = r_count + ONE;
                end
            end
            OP_REMOVE_FIRST: begin
                if (w_any) begin
                    w_ctl.cmd   = CMD_CLOSE_ALL;
                    n_block_out = w_val[0];
                    n_found     = 1'b1;
                    n_count     = r_count - ONE;
                end
            end
            OP_REMOVE_LAST: begin
                if (w_any) begin
                    n_block_out = w_tail;
                    n_found     = 1'b1;
                    n_count     = r_count - ONE;
                end
            end
            OP_REMOVE: begin
                if (w_hit[ENTRIES]) begin
                    w_ctl.cmd   = CMD_CLOSE;
                    n_block_out = i_in.block_id;
                    n_found     = 1'b1;
                    n_count     = r_count - ONE;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_block_out <= n_block_out;
            r_found     <= n_found;
            r_overflow  <= n_overflow;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.block_out   = r_block_out;
    assign o_out.found       = r_found;
    assign o_out.overflow    = r_overflow;
    assign o_out.entry_count = r_count;
    assign o_out.list_empty  = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("fill count beyond list depth");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.overflow |-> o_out.entry_count == FULL)
        else $error("insertion dropped while list not full");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_op == OP_CLEAR |=> r_count == '0)
        else $error("clear left entries behind");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && n_found && (w_op == OP_REMOVE || w_op == OP_REMOVE_FIRST
            || w_op == OP_REMOVE_LAST) |=> r_count == $past(r_count) - ONE)
        else $error("successful removal did not shrink the list by one");

    a_move_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_hit[ENTRIES] && (w_op == OP_MOVE_END || w_op == OP_MOVE_FRONT)
            |=> r_count == $past(r_count))
        else $error("move of a present block changed the count");

endmodule
